[rtl/core/ptme_pkg.sv]
`timescale 1ns / 1ps

package ptme_pkg;

    localparam int TABLE_PAGES_DEF = 16;
    localparam int ENTRIES         = 512;
    localparam int IDX_W           = 9;
    localparam int VA_W            = 48;
    localparam int VPN_W           = 36;
    localparam int ADDR_W          = 52;
    localparam int FLAG_W          = 12;
    localparam int PAGE_OFS_W      = 12;
    localparam int ADDED_W         = 2;
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_TABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALLOC_START = 2'd1;

    // Walk levels
    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_DIR  = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_LINK,
        ST_READ_INFO,
        ST_CHECK,
        ST_PTR,
        ST_ALLOC,
        ST_LEAF,
        ST_NEXT,
        ST_RESP
    } ptme_state_t;

    typedef enum logic {
        OP_ALLOC_PTR,
        OP_LEAF_ADDR
    } ptme_op_t;

    typedef struct packed {
        logic link_rd;
        logic info_rd;
        logic alloc_wr;
    } ptme_mem_ctl_t;

    // Pick the 9-bit table index of one level out of the virtual page number
    function automatic logic [IDX_W-1:0] ptme_level_index(input logic [VPN_W-1:0] vpn,
                                                          input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            2'd0:    idx = vpn[35:27];
            2'd1:    idx = vpn[26:18];
            2'd2:    idx = vpn[17:9];
            default: idx = vpn[8:0];
        endcase
        return idx;
    endfunction

endpackage

[rtl/core/ptme_req_if.sv]
`timescale 1ns / 1ps

interface ptme_req_if;
    import ptme_pkg::*;

    logic              valid;
    logic              ready;
    logic [VA_W-1:0]   virt_address;
    logic [ADDR_W-1:0] phys_address;
    logic [FLAG_W-1:0] flags;

    modport source (output valid, output virt_address, output phys_address, output flags,
                    input ready);
    modport sink   (input valid, input virt_address, input phys_address, input flags,
                    output ready);
endinterface

[rtl/core/ptme_rsp_if.sv]
`timescale 1ns / 1ps

interface ptme_rsp_if;
    import ptme_pkg::*;

    logic               valid;
    logic               ready;
    logic [ADDR_W-1:0]  leaf_entry_address;
    logic [ADDR_W-1:0]  leaf_value;
    logic [ADDED_W-1:0] tables_added;
    logic               out_of_space;
    logic [ADDR_W-1:0]  next_free_address;

    modport source (output valid, output leaf_entry_address, output leaf_value,
                    output tables_added, output out_of_space, output next_free_address,
                    input ready);
    modport sink   (input valid, input leaf_entry_address, input leaf_value,
                    input tables_added, input out_of_space, input next_free_address,
                    output ready);
endinterface

[rtl/core/ptme_cfg_if.sv]
`timescale 1ns / 1ps

interface ptme_cfg_if;
    import ptme_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [ADDR_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/ptme_add_unit.sv]
`timescale 1ns / 1ps

// Shared 52-bit adder: allocation pointer or leaf entry address, result registered.
module ptme_add_unit #(
    parameter int TABLE_PAGES = ptme_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = $clog2(TABLE_PAGES)
) (
    input  logic                        clk,
    input  ptme_pkg::ptme_op_t          op,
    input  logic [ptme_pkg::ADDR_W-1:0] alloc_base,
    input  logic [PAGE_W-1:0]           pages_used,
    input  logic [ptme_pkg::ADDR_W-1:0] page_base,
    input  logic [ptme_pkg::IDX_W-1:0]  leaf_index,
    output logic [ptme_pkg::ADDR_W-1:0] sum
);
    import ptme_pkg::*;

    logic [ADDR_W-1:0] opa;
    logic [ADDR_W-1:0] opb;
    logic [ADDR_W-1:0] sum_reg;

    always_comb
    begin
        case (op)
            OP_LEAF_ADDR:
            begin
                opa = page_base;
                opb = {{(ADDR_W-IDX_W-3){1'b0}}, leaf_index, 3'b000};
            end
            default:
            begin
                opa = alloc_base;
                opb = {{(ADDR_W-PAGE_W-PAGE_OFS_W){1'b0}}, pages_used,
                       {PAGE_OFS_W{1'b0}}};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= opa + opb;
    end

    assign sum = sum_reg;

endmodule

[rtl/core/ptme_store.sv]
`timescale 1ns / 1ps

// Table store: a child-page link per entry and a record per allocated page
// (parent slot, physical address). Both reads are registered.
module ptme_store #(
    parameter int TABLE_PAGES = ptme_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = $clog2(TABLE_PAGES),
    localparam int SLOT_W = PAGE_W + ptme_pkg::IDX_W,
    localparam int INFO_W = SLOT_W + ptme_pkg::ADDR_W
) (
    input  logic                    clk,
    input  ptme_pkg::ptme_mem_ctl_t mem_ctl,
    input  logic [SLOT_W-1:0]       link_addr,
    input  logic [PAGE_W-1:0]       link_wdata,
    output logic [PAGE_W-1:0]       link_rdata,
    input  logic [PAGE_W-1:0]       info_addr,
    input  logic [INFO_W-1:0]       info_wdata,
    output logic [INFO_W-1:0]       info_rdata
);
    import ptme_pkg::*;

    logic [PAGE_W-1:0] link_mem [TABLE_PAGES*ENTRIES];
    logic [INFO_W-1:0] info_mem [TABLE_PAGES];
    logic [PAGE_W-1:0] link_rdata_reg;
    logic [INFO_W-1:0] info_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (mem_ctl.alloc_wr)
        begin
            link_mem[link_addr] <= link_wdata;
        end
        if (mem_ctl.link_rd)
        begin
            link_rdata_reg <= link_mem[link_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_ctl.alloc_wr)
        begin
            info_mem[info_addr] <= info_wdata;
        end
        if (mem_ctl.info_rd)
        begin
            info_rdata_reg <= info_mem[info_addr];
        end
    end

    assign link_rdata = link_rdata_reg;
    assign info_rdata = info_rdata_reg;

endmodule

[rtl/core/ptme_seq.sv]
`timescale 1ns / 1ps

// Walk and allocation sequencer with the result register.
module ptme_seq #(
    parameter int TABLE_PAGES = ptme_pkg::TABLE_PAGES_DEF,
    localparam int PAGE_W = $clog2(TABLE_PAGES),
    localparam int SLOT_W = PAGE_W + ptme_pkg::IDX_W,
    localparam int INFO_W = SLOT_W + ptme_pkg::ADDR_W
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         req_valid,
    output logic                         req_ready,
    input  logic [ptme_pkg::VA_W-1:0]    virt_address,
    input  logic [ptme_pkg::ADDR_W-1:0]  phys_address,
    input  logic [ptme_pkg::FLAG_W-1:0]  flags,
    output logic                         rsp_valid,
    input  logic                         rsp_ready,
    output logic [ptme_pkg::ADDR_W-1:0]  leaf_entry_address,
    output logic [ptme_pkg::ADDR_W-1:0]  leaf_value,
    output logic [ptme_pkg::ADDED_W-1:0] tables_added,
    output logic                         out_of_space,
    output logic [ptme_pkg::ADDR_W-1:0]  next_free_address,
    input  logic [ptme_pkg::ADDR_W-1:0]  root_address,
    output ptme_pkg::ptme_op_t           add_op,
    output logic [ptme_pkg::ADDR_W-1:0]  page_base,
    output logic [ptme_pkg::IDX_W-1:0]   leaf_index,
    output logic [PAGE_W-1:0]            pages_used,
    input  logic [ptme_pkg::ADDR_W-1:0]  add_sum,
    output ptme_pkg::ptme_mem_ctl_t      mem_ctl,
    output logic [SLOT_W-1:0]            link_addr,
    output logic [PAGE_W-1:0]            link_wdata,
    input  logic [PAGE_W-1:0]            link_rdata,
    output logic [PAGE_W-1:0]            info_addr,
    output logic [INFO_W-1:0]            info_wdata,
    input  logic [INFO_W-1:0]            info_rdata
);
    import ptme_pkg::*;

    localparam int unsigned MAX_USED_I = TABLE_PAGES - 1;
    localparam logic [PAGE_W:0] MAX_USED = (PAGE_W+1)'(MAX_USED_I);

    ptme_state_t         state_reg, state_next;
    logic [1:0]          lvl_reg, lvl_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [PAGE_W-1:0]   pages_used_reg, pages_used_next;
    logic [ADDED_W-1:0]  added_reg, added_next;
    logic                oos_reg, oos_next;
    logic [VPN_W-1:0]    vpn_reg, vpn_next;
    logic [ADDR_W-1:0]   leaf_val_reg, leaf_val_next;
    logic [ADDR_W-1:0]   page_base_reg, page_base_next;
    logic [ADDR_W-1:0]   leaf_addr_reg, leaf_addr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0]   rsp_leaf_addr_reg, rsp_leaf_addr_next;
    logic [ADDR_W-1:0]   rsp_leaf_val_reg, rsp_leaf_val_next;
    logic [ADDED_W-1:0]  rsp_added_reg, rsp_added_next;
    logic                rsp_oos_reg, rsp_oos_next;
    logic [ADDR_W-1:0]   rsp_next_free_reg, rsp_next_free_next;

    logic [IDX_W-1:0]    cur_idx;
    logic [SLOT_W-1:0]   cur_slot;
    logic [PAGE_W-1:0]   new_page;
    logic [PAGE_W:0]     used_after;
    logic                entry_hit;

    assign cur_idx  = ptme_level_index(vpn_reg, lvl_reg);
    assign cur_slot = {page_reg, cur_idx};
    assign new_page = pages_used_reg + PAGE_W'(1);

    // An entry counts as present only when its link names an allocated page
    // whose record points back at this very slot; stale store contents fail this.
    assign entry_hit = (link_rdata != '0) && (link_rdata <= pages_used_reg)
                       && (info_rdata[INFO_W-1:ADDR_W] == cur_slot);

    assign used_after = {1'b0, pages_used_reg} + (PAGE_W+1)'(2'd3 - lvl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pages_used_reg <= '0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pages_used_reg <= pages_used_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg           <= lvl_next;
        page_reg          <= page_next;
        added_reg         <= added_next;
        oos_reg           <= oos_next;
        vpn_reg           <= vpn_next;
        leaf_val_reg      <= leaf_val_next;
        page_base_reg     <= page_base_next;
        leaf_addr_reg     <= leaf_addr_next;
        rsp_leaf_addr_reg <= rsp_leaf_addr_next;
        rsp_leaf_val_reg  <= rsp_leaf_val_next;
        rsp_added_reg     <= rsp_added_next;
        rsp_oos_reg       <= rsp_oos_next;
        rsp_next_free_reg <= rsp_next_free_next;
    end

    always_comb
    begin
        state_next         = state_reg;
        lvl_next           = lvl_reg;
        page_next          = page_reg;
        pages_used_next    = pages_used_reg;
        added_next         = added_reg;
        oos_next           = oos_reg;
        vpn_next           = vpn_reg;
        leaf_val_next      = leaf_val_reg;
        page_base_next     = page_base_reg;
        leaf_addr_next     = leaf_addr_reg;
        rsp_valid_next     = rsp_valid_reg && !rsp_ready;
        rsp_leaf_addr_next = rsp_leaf_addr_reg;
        rsp_leaf_val_next  = rsp_leaf_val_reg;
        rsp_added_next     = rsp_added_reg;
        rsp_oos_next       = rsp_oos_reg;
        rsp_next_free_next = rsp_next_free_reg;

        req_ready  = 1'b0;
        add_op     = OP_ALLOC_PTR;
        mem_ctl    = '0;
        link_addr  = cur_slot;
        link_wdata = new_page;
        info_addr  = link_rdata;
        info_wdata = {cur_slot, add_sum};

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    vpn_next      = virt_address[VA_W-1:PAGE_OFS_W];
                    leaf_val_next = phys_address | {{(ADDR_W-FLAG_W){1'b0}}, flags};
                    lvl_next      = LVL_TOP;
                    page_next     = '0;
                    added_next    = '0;
                    oos_next      = 1'b0;
                    state_next    = ST_READ_LINK;
                end
            end
            ST_READ_LINK:
            begin
                mem_ctl.link_rd = 1'b1;
                state_next      = ST_READ_INFO;
            end
            ST_READ_INFO:
            begin
                mem_ctl.info_rd = 1'b1;
                state_next      = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (entry_hit)
                begin
                    page_next      = link_rdata;
                    page_base_next = info_rdata[ADDR_W-1:0];
                    if (lvl_reg == LVL_DIR)
                    begin
                        lvl_next   = LVL_LEAF;
                        state_next = ST_LEAF;
                    end
                    else
                    begin
                        lvl_next   = lvl_reg + 2'd1;
                        state_next = ST_READ_LINK;
                    end
                end
                else if (used_after > MAX_USED)
                begin
                    oos_next   = 1'b1;
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_PTR;
                end
            end
            ST_PTR:
            begin
                state_next = ST_ALLOC;
            end
            ST_ALLOC:
            begin
                // add_sum holds the pointer for the page being claimed
                mem_ctl.alloc_wr = 1'b1;
                info_addr        = new_page;
                pages_used_next  = new_page;
                added_next       = added_reg + ADDED_W'(1);
                page_next        = new_page;
                page_base_next   = add_sum;
                if (lvl_reg == LVL_DIR)
                begin
                    lvl_next   = LVL_LEAF;
                    state_next = ST_LEAF;
                end
                else
                begin
                    lvl_next   = lvl_reg + 2'd1;
                    state_next = ST_PTR;
                end
            end
            ST_LEAF:
            begin
                add_op     = OP_LEAF_ADDR;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                leaf_addr_next = add_sum;
                state_next     = ST_RESP;
            end
            ST_RESP:
            begin
                // hold until the result register is free
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_leaf_addr_next = oos_reg ? '0 : leaf_addr_reg;
                    rsp_leaf_val_next  = oos_reg ? '0 : leaf_val_reg;
                    rsp_added_next     = oos_reg ? '0 : added_reg;
                    rsp_oos_next       = oos_reg;
                    rsp_next_free_next = add_sum;
                    state_next         = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign page_base  = (page_reg == '0) ? root_address : page_base_reg;
    assign leaf_index = cur_idx;
    assign pages_used = pages_used_reg;

    assign rsp_valid          = rsp_valid_reg;
    assign leaf_entry_address = rsp_leaf_addr_reg;
    assign leaf_value         = rsp_leaf_val_reg;
    assign tables_added       = rsp_added_reg;
    assign out_of_space       = rsp_oos_reg;
    assign next_free_address  = rsp_next_free_reg;

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, pages_used_reg} <= MAX_USED)
        else $error("page count beyond the store");

    a_pages_only_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_ALLOC) |=> $stable(pages_used_reg))
        else $error("page count moved outside allocation");

    a_alloc_link: assert property (@(posedge clk) disable iff (!rst_n)
        mem_ctl.alloc_wr |-> (link_wdata != '0) && (info_addr == link_wdata))
        else $error("allocation writes the root or a mismatched record");

    a_oos_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_oos_reg) |-> (rsp_added_reg == '0)
            && (rsp_leaf_val_reg == '0) && (rsp_leaf_addr_reg == '0))
        else $error("out-of-space result carries a mapping");

endmodule

[rtl/core/page_table_map_engine.sv]
// Channel | Dir | Beat payload                                          | Accepted when
// cfg     | in  | index, data (root table address / allocation start)   | valid && ready
// req     | in  | virt_address, phys_address, flags                     | valid && ready
// rsp     | out | leaf_entry_address, leaf_value, tables_added,         | valid && ready
//         |     | out_of_space, next_free_address                       |
//
// A request walks the levels one at a time: until an entry is missing, each of the
// top three levels takes two dependent store reads (entry link, then the page
// record) plus a check; each new table then takes a pointer and an allocation step
// on the shared adder. req is ready again as the result beat rises.
// No clearing pass after reset: an entry is trusted only when the page it links
// to is allocated and points back at it. cfg is always ready. A stalled rsp
// holds its beat; the next request may run meanwhile and waits at its end.
`timescale 1ns / 1ps

module page_table_map_engine #(
    parameter int TABLE_PAGES = ptme_pkg::TABLE_PAGES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    ptme_cfg_if.sink   cfg,
    ptme_req_if.sink   req,
    ptme_rsp_if.source rsp
);
    import ptme_pkg::*;

    localparam int PAGE_W = $clog2(TABLE_PAGES);
    localparam int SLOT_W = PAGE_W + IDX_W;
    localparam int INFO_W = SLOT_W + ADDR_W;

    // Configuration: root kept page-aligned, allocation start rounded up to 4 KiB
    logic [ADDR_W-1:0]            root_addr_reg, root_addr_next;
    logic [ADDR_W-1:0]            alloc_base_reg, alloc_base_next;
    logic [ADDR_W-PAGE_OFS_W-1:0] start_page;

    // Sequencer to store and adder
    ptme_op_t          add_op;
    logic [ADDR_W-1:0] page_base;
    logic [IDX_W-1:0]  leaf_index;
    logic [PAGE_W-1:0] pages_used;
    logic [ADDR_W-1:0] add_sum;
    ptme_mem_ctl_t     mem_ctl;
    logic [SLOT_W-1:0] link_addr;
    logic [PAGE_W-1:0] link_wdata;
    logic [PAGE_W-1:0] link_rdata;
    logic [PAGE_W-1:0] info_addr;
    logic [INFO_W-1:0] info_wdata;
    logic [INFO_W-1:0] info_rdata;

    assign cfg.ready = 1'b1;

    // Round the start up: bump the page number when any offset bit is set, wrap at 52 bits
    assign start_page = (cfg.data[PAGE_OFS_W-1:0] != '0)
                        ? cfg.data[ADDR_W-1:PAGE_OFS_W] + (ADDR_W-PAGE_OFS_W)'(1)
                        : cfg.data[ADDR_W-1:PAGE_OFS_W];

    always_comb
    begin
        root_addr_next  = root_addr_reg;
        alloc_base_next = alloc_base_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_ROOT_TABLE:  root_addr_next  = {cfg.data[ADDR_W-1:PAGE_OFS_W],
                                                    {PAGE_OFS_W{1'b0}}};
                CFG_ALLOC_START: alloc_base_next = {start_page, {PAGE_OFS_W{1'b0}}};
                default:
                begin
                    // drop writes to unknown registers
                    root_addr_next  = root_addr_reg;
                    alloc_base_next = alloc_base_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            root_addr_reg  <= '0;
            alloc_base_reg <= '0;
        end
        else
        begin
            root_addr_reg  <= root_addr_next;
            alloc_base_reg <= alloc_base_next;
        end
    end

    // Walk, allocate and hold the result beat
    ptme_seq #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_seq (
        .clk                (clk),
        .rst_n              (rst_n),
        .req_valid          (req.valid),
        .req_ready          (req.ready),
        .virt_address       (req.virt_address),
        .phys_address       (req.phys_address),
        .flags              (req.flags),
        .rsp_valid          (rsp.valid),
        .rsp_ready          (rsp.ready),
        .leaf_entry_address (rsp.leaf_entry_address),
        .leaf_value         (rsp.leaf_value),
        .tables_added       (rsp.tables_added),
        .out_of_space       (rsp.out_of_space),
        .next_free_address  (rsp.next_free_address),
        .root_address       (root_addr_reg),
        .add_op             (add_op),
        .page_base          (page_base),
        .leaf_index         (leaf_index),
        .pages_used         (pages_used),
        .add_sum            (add_sum),
        .mem_ctl            (mem_ctl),
        .link_addr          (link_addr),
        .link_wdata         (link_wdata),
        .link_rdata         (link_rdata),
        .info_addr          (info_addr),
        .info_wdata         (info_wdata),
        .info_rdata         (info_rdata)
    );

    // One adder serves both the allocation pointer and the leaf entry address
    ptme_add_unit #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_add (
        .clk        (clk),
        .op         (add_op),
        .alloc_base (alloc_base_reg),
        .pages_used (pages_used),
        .page_base  (page_base),
        .leaf_index (leaf_index),
        .sum        (add_sum)
    );

    // Entry links and per-page records
    ptme_store #(
        .TABLE_PAGES (TABLE_PAGES)
    ) u_store (
        .clk        (clk),
        .mem_ctl    (mem_ctl),
        .link_addr  (link_addr),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .info_addr  (info_addr),
        .info_wdata (info_wdata),
        .info_rdata (info_rdata)
    );

endmodule
